// ===== rtl/pidpi_pkg.sv =====
// Shared types and constants of the PID position and increment controller.
`timescale 1ns / 1ps

package pidpi_pkg;

  // Fixed field widths of the configuration registers and of the drive result.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DriveW   = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned ZoneW    = 16;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // Register indexes on the configuration channel.
  localparam cfg_idx_t RegMode       = cfg_idx_t'(0);
  localparam cfg_idx_t RegPropGain   = cfg_idx_t'(1);
  localparam cfg_idx_t RegIntegGain  = cfg_idx_t'(2);
  localparam cfg_idx_t RegDerivGain  = cfg_idx_t'(3);
  localparam cfg_idx_t RegDriveLimit = cfg_idx_t'(4);
  localparam cfg_idx_t RegIntegLimit = cfg_idx_t'(5);
  localparam cfg_idx_t RegClearZone  = cfg_idx_t'(6);
  localparam cfg_idx_t RegDeadZone   = cfg_idx_t'(7);

  typedef enum logic {
    ModePositional  = 1'b0,
    ModeIncremental = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [GainW-1:0]  prop_gain;
    logic [GainW-1:0]  integ_gain;
    logic [GainW-1:0]  deriv_gain;
    logic [LimitW-1:0] drive_limit;
    logic [LimitW-1:0] integ_limit;
    logic [ZoneW-1:0]  clear_zone;
    logic [ZoneW-1:0]  dead_zone;
  } cfg_t;

  localparam logic [LimitW-1:0] LimitReset = {LimitW{1'b1}};

endpackage

// ===== rtl/pidpi_cfg_if.sv =====
// Configuration write channel of the PID controller.
`timescale 1ns / 1ps

interface pidpi_cfg_if;
  logic                                valid;
  logic                                ready;
  pidpi_pkg::cfg_idx_t                 index;
  logic [pidpi_pkg::CfgDataW-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pidpi_sample_if.sv =====
// Sample request channel of the PID controller: setpoint and measured value.
`timescale 1ns / 1ps

interface pidpi_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] setpoint;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

// ===== rtl/pidpi_drive_if.sv =====
// Drive result channel of the PID controller.
`timescale 1ns / 1ps

interface pidpi_drive_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pidpi_pkg::DriveW-1:0]   drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== rtl/pidpi_cfg_regs.sv =====
// Configuration register file of the PID controller.
`timescale 1ns / 1ps

module pidpi_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  pidpi_cfg_if.sink         cfg_i,
  output pidpi_pkg::cfg_t   cfg_o
);

  pidpi_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_i.index)
        pidpi_pkg::RegMode:       cfg_d.mode        = pidpi_pkg::mode_e'(cfg_i.data[0]);
        pidpi_pkg::RegPropGain:   cfg_d.prop_gain   = cfg_i.data[pidpi_pkg::GainW-1:0];
        pidpi_pkg::RegIntegGain:  cfg_d.integ_gain  = cfg_i.data[pidpi_pkg::GainW-1:0];
        pidpi_pkg::RegDerivGain:  cfg_d.deriv_gain  = cfg_i.data[pidpi_pkg::GainW-1:0];
        pidpi_pkg::RegDriveLimit: cfg_d.drive_limit = cfg_i.data[pidpi_pkg::LimitW-1:0];
        pidpi_pkg::RegIntegLimit: cfg_d.integ_limit = cfg_i.data[pidpi_pkg::LimitW-1:0];
        pidpi_pkg::RegClearZone:  cfg_d.clear_zone  = cfg_i.data[pidpi_pkg::ZoneW-1:0];
        pidpi_pkg::RegDeadZone:   cfg_d.dead_zone   = cfg_i.data[pidpi_pkg::ZoneW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= pidpi_pkg::ModePositional;
      cfg_q.prop_gain   <= '0;
      cfg_q.integ_gain  <= '0;
      cfg_q.deriv_gain  <= '0;
      cfg_q.drive_limit <= pidpi_pkg::LimitReset;
      cfg_q.integ_limit <= pidpi_pkg::LimitReset;
      cfg_q.clear_zone  <= '0;
      cfg_q.dead_zone   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pidpi_core.sv =====
// Control law of the PID controller with its loop state (last error, integral, held drive).
`timescale 1ns / 1ps

module pidpi_core #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidpi_pkg::cfg_t                      cfg_i,
  input  logic                                 step_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       measured_i,
  output logic signed [pidpi_pkg::DriveW-1:0]  drive_o
);

  localparam int unsigned EW     = SAMPLE_WIDTH + 1;
  localparam int unsigned DW     = SAMPLE_WIDTH + 2;
  localparam int unsigned GW     = pidpi_pkg::GainW + 1;
  localparam int unsigned PE_W   = EW + GW;
  localparam int unsigned PD_W   = DW + GW;
  localparam int unsigned ACC_W  = GAIN_FRAC_BITS + pidpi_pkg::LimitW + 2;
  localparam int unsigned ASUM_W = ((PE_W > ACC_W) ? PE_W : ACC_W) + 1;
  localparam int unsigned POS_W  = ((PD_W > ACC_W) ? PD_W : ACC_W) + 2;
  localparam int unsigned HSH_W  = pidpi_pkg::DriveW + GAIN_FRAC_BITS;
  localparam int unsigned INC_W  = ((PD_W + 1 > HSH_W) ? PD_W + 1 : HSH_W) + 1;
  localparam int unsigned TOT_W  = ((POS_W > INC_W) ? POS_W : INC_W) + 1;
  localparam int unsigned MW     = (EW > pidpi_pkg::ZoneW) ? EW : pidpi_pkg::ZoneW;
  localparam logic [TOT_W-1:0] FracMask = TOT_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic signed [EW-1:0]                last_error_q;
  logic signed [ACC_W-1:0]             acc_q, acc_new;
  logic signed [pidpi_pkg::DriveW-1:0] held_q;

  logic signed [EW-1:0]     err;
  logic signed [DW-1:0]     derr;
  logic [EW-1:0]            mag;
  logic [MW-1:0]            mag_w, clear_w, dead_w;
  logic signed [GW-1:0]     kp_s, ki_s, kd_s;
  logic signed [PE_W-1:0]   p_err, i_err;
  logic signed [PD_W-1:0]   d_derr, p_derr;
  logic signed [ASUM_W-1:0] acc_sum, ilim, acc_clamp;
  logic signed [TOT_W-1:0]  pos_sum, inc_delta, inc_sum, sum, sum_adj, sum_q, dlim, dclamp;

  always_comb begin
    err     = EW'(setpoint_i) - EW'(measured_i);
    derr    = DW'(err) - DW'(last_error_q);
    mag     = err[EW-1] ? EW'(-err) : EW'(err);
    mag_w   = MW'(mag);
    clear_w = MW'(cfg_i.clear_zone);
    dead_w  = MW'(cfg_i.dead_zone);

    kp_s = $signed({1'b0, cfg_i.prop_gain});
    ki_s = $signed({1'b0, cfg_i.integ_gain});
    kd_s = $signed({1'b0, cfg_i.deriv_gain});

    p_err  = PE_W'(kp_s) * PE_W'(err);
    i_err  = PE_W'(ki_s) * PE_W'(err);
    d_derr = PD_W'(kd_s) * PD_W'(derr);
    p_derr = PD_W'(kp_s) * PD_W'(derr);

    // Positional: accumulate, clamp symmetrically, then clear inside the clear zone.
    acc_sum = ASUM_W'(acc_q) + ASUM_W'(i_err);
    ilim    = ASUM_W'($signed({1'b0, cfg_i.integ_limit})) <<< GAIN_FRAC_BITS;
    if (acc_sum > ilim) begin
      acc_clamp = ilim;
    end else if (acc_sum < -ilim) begin
      acc_clamp = -ilim;
    end else begin
      acc_clamp = acc_sum;
    end
    acc_new = (mag_w < clear_w) ? '0 : ACC_W'(acc_clamp);
    pos_sum = TOT_W'(p_err) + TOT_W'(acc_new) + TOT_W'(d_derr);

    // Incremental: the integral term only applies outside the clear zone.
    inc_delta = TOT_W'(p_derr) + ((mag_w > clear_w) ? TOT_W'(i_err) : '0);
    inc_sum   = (TOT_W'(held_q) <<< GAIN_FRAC_BITS) + inc_delta;

    sum = (cfg_i.mode == pidpi_pkg::ModeIncremental) ? inc_sum : pos_sum;

    // Truncate toward zero: bias negative values before the arithmetic shift.
    sum_adj = sum + (sum[TOT_W-1] ? $signed(FracMask) : TOT_W'(0));
    sum_q   = sum_adj >>> GAIN_FRAC_BITS;

    dlim = TOT_W'($signed({1'b0, cfg_i.drive_limit}));
    if (sum_q > dlim) begin
      dclamp = dlim;
    end else if (sum_q < -dlim) begin
      dclamp = -dlim;
    end else begin
      dclamp = sum_q;
    end
    drive_o = (mag_w < dead_w) ? '0 : pidpi_pkg::DriveW'(dclamp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      acc_q        <= '0;
      held_q       <= '0;
    end else if (step_i) begin
      last_error_q <= err;
      held_q       <= drive_o;
      if (cfg_i.mode == pidpi_pkg::ModePositional) begin
        acc_q <= acc_new;
      end
    end
  end

endmodule

// ===== rtl/pid_position_increment_controller_top.sv =====
// Top level of the PID position and increment controller.
`timescale 1ns / 1ps

// Channel   Direction  Payload                       Handshake
// cfg_i     in         index, data                   valid / ready
// sample_i  in         setpoint, measured            valid / ready
// drive_o   out        drive                         valid / ready
//
// Each sample request is captured in an input register; when it moves on, the
// whole control law is evaluated and written to the output register together
// with the loop state, and the result is offered on drive_o from there. One
// request is taken every cycle while drive_o does not stall. The clock period
// is bounded by that single pass through the four gain multipliers, the sums
// and the clamps.
// Reset clears the loop state and the handshake flags and loads the register
// defaults (both limits at full scale, all gains and zones at zero).
// While the output register holds a result that is not taken, one more request
// is still captured in the input register; only then is sample_i held off.

module pid_position_increment_controller_top #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pidpi_cfg_if.sink          cfg_i,
  pidpi_sample_if.sink       sample_i,
  pidpi_drive_if.source      drive_o
);

  pidpi_pkg::cfg_t cfg;

  // Input register: one request waiting for evaluation.
  logic                           in_valid_q, in_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] setpoint_q, measured_q;

  // Output register: one finished drive value waiting to be taken.
  logic                                 out_valid_q, out_valid_d;
  logic signed [pidpi_pkg::DriveW-1:0]  drive_q, drive_next;

  logic in_accept;
  logic advance;

  pidpi_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pidpi_core #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (advance),
    .setpoint_i (setpoint_q),
    .measured_i (measured_q),
    .drive_o    (drive_next)
  );

  // A request moves on when the output register is empty or being emptied;
  // the loop state is updated on that same edge, ready for the next request.
  assign advance        = in_valid_q && (!out_valid_q || drive_o.ready);
  assign sample_i.ready = !in_valid_q || advance;
  assign in_accept      = sample_i.valid && sample_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (drive_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      setpoint_q <= sample_i.setpoint;
      measured_q <= sample_i.measured;
    end
    if (advance) begin
      drive_q <= drive_next;
    end
  end

  assign drive_o.valid = out_valid_q;
  assign drive_o.drive = drive_q;

endmodule

// ===== test/pid_drive_checker.sv =====
// Checker for the PID controller: tracks settings and loop state and compares every drive.
`timescale 1ns / 1ps

module pid_drive_checker #(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pidpi_cfg_if        cfg_i,
  pidpi_sample_if     sample_i,
  pidpi_drive_if      drive_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import pidpi_pkg::*;

  cfg_t                           regs_q;
  logic signed [SAMPLE_WIDTH:0]   err_prev_q;
  logic signed [39:0]             integ_q;
  logic signed [DriveW-1:0]       drive_held_q;
  logic signed [DriveW-1:0]       drive_expected_q[$];

  // Drop the fraction bits, truncating towards zero.
  function automatic longint fixed_to_int(input longint v);
    if (v < 0) return -((-v) >>> GAIN_FRAC_BITS);
    return v >>> GAIN_FRAC_BITS;
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : control_law
    longint                   error_now;
    longint                   error_step;
    longint                   error_mag;
    longint                   integ_next;
    longint                   law_sum;
    longint                   drive_next;
    logic signed [DriveW-1:0] drive_want;
    if (!rst_ni) begin
      regs_q.mode        <= ModePositional;
      regs_q.prop_gain   <= '0;
      regs_q.integ_gain  <= '0;
      regs_q.deriv_gain  <= '0;
      regs_q.drive_limit <= LimitReset;
      regs_q.integ_limit <= LimitReset;
      regs_q.clear_zone  <= '0;
      regs_q.dead_zone   <= '0;
      err_prev_q         <= '0;
      integ_q            <= '0;
      drive_held_q       <= '0;
      drive_expected_q.delete();
      fail_count_o       <= 0;
      pending_o          <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegMode:       regs_q.mode        <= mode_e'(cfg_i.data[0]);
          RegPropGain:   regs_q.prop_gain   <= cfg_i.data;
          RegIntegGain:  regs_q.integ_gain  <= cfg_i.data;
          RegDerivGain:  regs_q.deriv_gain  <= cfg_i.data;
          RegDriveLimit: regs_q.drive_limit <= cfg_i.data[LimitW-1:0];
          RegIntegLimit: regs_q.integ_limit <= cfg_i.data[LimitW-1:0];
          RegClearZone:  regs_q.clear_zone  <= cfg_i.data;
          RegDeadZone:   regs_q.dead_zone   <= cfg_i.data;
          default: ;
        endcase
      end

      // Results are matched before this edge's request is queued, so a drive can
      // never be paired with a request taken in the same cycle.
      if (drive_i.valid && drive_i.ready) begin
        if (drive_expected_q.size() == 0) begin
          $display("%0t: unexpected drive: expected none, actual %0d", $time, drive_i.drive);
          fail_count_o <= fail_count_o + 1;
        end else begin
          drive_want = drive_expected_q.pop_front();
          if (drive_i.drive !== drive_want) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d",
                     $time, drive_want, drive_i.drive);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end

      if (sample_i.valid && sample_i.ready) begin
        error_now  = longint'(sample_i.setpoint) - longint'(sample_i.measured);
        error_step = error_now - longint'(err_prev_q);
        error_mag  = (error_now < 0) ? -error_now : error_now;
        if (regs_q.mode == ModePositional) begin
          integ_next = clamp_sym(longint'(integ_q) + longint'(regs_q.integ_gain) * error_now,
                                 longint'(regs_q.integ_limit) <<< GAIN_FRAC_BITS);
          if (error_mag < longint'(regs_q.clear_zone)) integ_next = 0;
          law_sum = longint'(regs_q.prop_gain) * error_now + integ_next
                  + longint'(regs_q.deriv_gain) * error_step;
          integ_q <= integ_next[39:0];
        end else begin
          law_sum = longint'(regs_q.prop_gain) * error_step;
          if (error_mag > longint'(regs_q.clear_zone)) begin
            law_sum = law_sum + longint'(regs_q.integ_gain) * error_now;
          end
          law_sum = law_sum + (longint'(drive_held_q) <<< GAIN_FRAC_BITS);
        end
        drive_next = clamp_sym(fixed_to_int(law_sum), longint'(regs_q.drive_limit));
        if (error_mag < longint'(regs_q.dead_zone)) drive_next = 0;
        drive_held_q <= drive_next[DriveW-1:0];
        err_prev_q   <= error_now[SAMPLE_WIDTH:0];
        drive_expected_q.push_back(drive_next[DriveW-1:0]);
      end

      pending_o <= drive_expected_q.size();
    end
  end

endmodule

// ===== test/pid_position_increment_controller_top_tb.sv =====
// Testbench top of the PID controller: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module pid_position_increment_controller_top_tb;
  import pidpi_pkg::*;

  localparam int unsigned SampleW       = 16;
  localparam int unsigned GainFrac      = 8;
  localparam int          SampleMax     = 2 ** (SampleW - 1) - 1;
  localparam int          SampleMin     = -(2 ** (SampleW - 1));
  localparam int unsigned RandomPhases  = 14;
  localparam int unsigned PhaseRequests = 100;
  localparam int unsigned SettleCycles  = 8;
  // The slowest correct run stays far below this: every request waits out at
  // most a short sender gap plus a receiver stall, and the result follows its
  // request through the input and output registers.
  localparam int unsigned CycleLimit    = 500000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_len;

  pidpi_cfg_if                            cfg_bus ();
  pidpi_sample_if #(.SAMPLE_WIDTH(SampleW)) sample_bus ();
  pidpi_drive_if                          drive_bus ();

  pid_position_increment_controller_top #(
    .SAMPLE_WIDTH  (SampleW),
    .GAIN_FRAC_BITS(GainFrac)
  ) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .sample_i(sample_bus),
    .drive_o (drive_bus)
  );

  pid_drive_checker #(
    .SAMPLE_WIDTH  (SampleW),
    .GAIN_FRAC_BITS(GainFrac)
  ) u_drive_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_i       (cfg_bus),
    .sample_i    (sample_bus),
    .drive_i     (drive_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver changes its behaviour over random spans: always ready,
  // coin-flip stalls, rare stalls, or mostly stalled with the odd accepted result.
  initial begin : drive_sink
    int unsigned style;
    int unsigned span;
    drive_bus.ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        case (style)
          0:       drive_bus.ready <= 1'b1;
          1:       drive_bus.ready <= 1'($urandom_range(0, 1));
          2:       drive_bus.ready <= ($urandom_range(0, 7) != 0);
          default: drive_bus.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  function automatic cfg_t make_settings(input mode_e m,
                                         input logic [GainW-1:0] kp, ki, kd,
                                         input logic [LimitW-1:0] dl, il,
                                         input logic [ZoneW-1:0] cz, dz);
    cfg_t s;
    s.mode        = m;
    s.prop_gain   = kp;
    s.integ_gain  = ki;
    s.deriv_gain  = kd;
    s.drive_limit = dl;
    s.integ_limit = il;
    s.clear_zone  = cz;
    s.dead_zone   = dz;
    return s;
  endfunction

  // Gains lean towards modest values so that the drive is not always saturated.
  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      6:       return GainW'($urandom_range(0, 16'h2000));
      7:       return GainW'($urandom);
      default: return GainW'($urandom_range(0, 16'h0200));
    endcase
  endfunction

  function automatic logic [LimitW-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return LimitW'($urandom);
      default: return LimitW'($urandom_range(0, 16'h2000));
    endcase
  endfunction

  // Zones are mostly narrow so that both sides of each threshold are reached.
  function automatic logic [ZoneW-1:0] pick_zone();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      6, 7:    return ZoneW'($urandom);
      default: return ZoneW'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic cfg_t random_settings();
    return make_settings(mode_e'($urandom_range(0, 1)), pick_gain(), pick_gain(),
                         pick_gain(), pick_limit(), pick_limit(), pick_zone(), pick_zone());
  endfunction

  // One configuration request; valid stays high for the next write.
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers are only rewritten once the block has drained: the sender is
  // stopped, every expected drive has arrived and a few cycles have passed.
  // Unused bits of the narrow registers carry random values, and a write to an
  // index past the last register must leave every setting alone.
  task automatic apply_settings(input cfg_t s);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom);
    sample_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(RegMode,       {noise[CfgDataW-1:1], s.mode});
    write_reg(RegPropGain,   s.prop_gain);
    write_reg(RegIntegGain,  s.integ_gain);
    write_reg(RegDerivGain,  s.deriv_gain);
    write_reg(RegDriveLimit, {noise[0], s.drive_limit});
    write_reg(RegIntegLimit, {noise[1], s.integ_limit});
    write_reg(RegClearZone,  s.clear_zone);
    write_reg(RegDeadZone,   s.dead_zone);
    write_reg(cfg_idx_t'($urandom_range(2 ** CfgIdxW - 1, RegDeadZone + 1)),
              CfgDataW'($urandom));
    cfg_bus.valid <= 1'b0;
  endtask

  // One sample request. The sender works in bursts; between bursts it may drop
  // valid for a short random gap, or carry straight on with no gap at all.
  task automatic send_sample(input logic signed [SampleW-1:0] sp,
                             input logic signed [SampleW-1:0] ms);
    sample_bus.valid    <= 1'b1;
    sample_bus.setpoint <= sp;
    sample_bus.measured <= ms;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        sample_bus.valid <= 1'b0;
        repeat (gap_len) @(negedge clk);
      end
    end
  endtask

  // Most requests hold a small error around a random setpoint, so that the
  // dead zone, the clear zone and the integral clamp all come into play; the
  // rest are fully random or sit at the ends of the sample range.
  task automatic random_sample(output logic signed [SampleW-1:0] sp,
                               output logic signed [SampleW-1:0] ms);
    int          set_val;
    int          meas_val;
    int unsigned span;
    case ($urandom_range(0, 7))
      0, 1: begin
        set_val  = int'($urandom_range(0, 2 ** SampleW - 1)) + SampleMin;
        meas_val = int'($urandom_range(0, 2 ** SampleW - 1)) + SampleMin;
      end
      2: begin
        set_val  = $urandom_range(0, 1) ? SampleMax : SampleMin;
        meas_val = $urandom_range(0, 1) ? SampleMax : SampleMin;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       span = 8;
          1:       span = 256;
          default: span = 4096;
        endcase
        set_val  = int'($urandom_range(0, 2 ** SampleW - 1)) + SampleMin;
        meas_val = set_val - (int'($urandom_range(0, 2 * span)) - int'(span));
        if (meas_val > SampleMax) meas_val = SampleMax;
        if (meas_val < SampleMin) meas_val = SampleMin;
      end
    endcase
    sp = set_val[SampleW-1:0];
    ms = meas_val[SampleW-1:0];
  endtask

  initial begin : stimulus
    cfg_t                        s;
    logic signed [SampleW-1:0]   sp;
    logic signed [SampleW-1:0]   ms;
    rst_n               = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.data        = '0;
    sample_bus.valid    = 1'b0;
    sample_bus.setpoint = '0;
    sample_bus.measured = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With the reset settings all gains are zero, so the drive must be zero.
    send_sample(16'sd1234, -16'sd1234);

    // Positional law with a tight integral clamp: full-scale errors in both
    // directions drive the integral onto its upper and then its lower bound.
    apply_settings(make_settings(ModePositional, 16'h0100, 16'h0040, 16'h0080,
                                 15'h7FFF, 15'd50, 16'd0, 16'd0));
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sd100, 16'sd90);
    send_sample(16'sd90, 16'sd100);
    send_sample(16'sd7, 16'sd7);

    // Positional law with both zones: an error inside the clear zone empties
    // the integral, and one inside the dead zone forces the drive to zero.
    apply_settings(make_settings(ModePositional, 16'h0100, 16'h0100, 16'h0040,
                                 15'h7FFF, 15'd2000, 16'd20, 16'd5));
    send_sample(16'sd30, 16'sd0);
    send_sample(16'sd19, 16'sd0);
    send_sample(16'sd4, 16'sd0);
    send_sample(-16'sd5, 16'sd0);
    send_sample(-16'sd25, 16'sd0);

    // Incremental law, switched in with the loop state left from above: the
    // integral step only counts beyond the clear zone, and a dead-zone zero
    // also resets the held drive.
    apply_settings(make_settings(ModeIncremental, 16'h0100, 16'h0100, 16'hFFFF,
                                 15'd1000, 15'd100, 16'd10, 16'd3));
    send_sample(16'sd50, 16'sd0);
    send_sample(16'sd50, 16'sd0);
    send_sample(16'sd10, 16'sd0);
    send_sample(16'sd11, 16'sd0);
    send_sample(16'sd2, 16'sd0);
    send_sample(-16'sd40, 16'sd0);
    send_sample(16'sh7FFF, -16'sh8000);

    // Both limits at zero: the drive is pinned at zero whatever the gains.
    apply_settings(make_settings(ModePositional, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 15'd0, 15'd0, 16'd0, 16'd0));
    send_sample(16'sd1000, 16'sd0);
    send_sample(-16'sd1000, 16'sd0);

    // Random phases: the first two at the extremes of the settings, the third with zero limits.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: s = make_settings(ModePositional, '1, '1, '1, '1, '1, '0, '0);
        1: s = make_settings(ModeIncremental, '1, '1, '1, '1, '1, '0, '0);
        2: s = make_settings(mode_e'($urandom_range(0, 1)), pick_gain(), pick_gain(),
                             pick_gain(), '0, '0, pick_zone(), pick_zone());
        default: s = random_settings();
      endcase
      apply_settings(s);
      repeat (PhaseRequests) begin
        random_sample(sp, ms);
        send_sample(sp, ms);
      end
    end

    // Drain: every expected drive must arrive, and any stray result that follows
    // is counted as a failure by the checker.
    sample_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
